// File: rtl/mpe_pkg.sv
// Shared constants, types and the loglog table for the Mandelbrot escape color block.
// No dependencies.
package mpe_pkg;

  localparam int MAX_FRAME_DIM = 1024;
  localparam int MAX_ITER_BOUND = 4095;
  localparam int LOGLOG_TABLE_DEPTH = 256;

  localparam int POS_W = $clog2(MAX_FRAME_DIM);
  localparam int DIM_W = POS_W + 1;
  localparam int ITER_W = $clog2(MAX_ITER_BOUND + 1);
  localparam int LL_IDX_W = $clog2(LOGLOG_TABLE_DEPTH);
  localparam int LL_W = 18;
  localparam int FRAC = 28;
  localparam int COORD_W = 32;
  localparam int STEP_W = 31;
  localparam int Z_W = 34;
  localparam int SQ_W = 36;
  localparam int MAG_W = SQ_W + 1;
  localparam int MUL_W = 33;
  localparam int S_W = ITER_W + 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [MAG_W-1:0] ESCAPE_SQ = MAG_W'(64'd4 << FRAC);

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_REAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IMAG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd5;

  localparam logic [MUL_W-1:0] K_RED = MUL_W'(2295);
  localparam logic [MUL_W-1:0] K_GREEN = MUL_W'(3825);
  localparam logic [MUL_W-1:0] K_BLUE = MUL_W'(4335);

  typedef struct packed {
    logic start;
    logic [S_W-1:0] dividend;
    logic [ITER_W-1:0] divisor;
  } mpe_div_req_t;

  typedef logic [LL_W-1:0] ll_tab_t [LOGLOG_TABLE_DEPTH];

  function automatic longint log2_q16(input logic [63:0] v, input int frac);
    int p;
    logic [63:0] m;
    longint r;
    p = 0;
    for (int k = 0; k < 64; k++) begin
      if (v[k]) p = k;
    end
    if (v == 64'd0) return 0;
    m = (p > 30) ? (v >> (p - 30)) : (v << (30 - p));
    r = longint'(p - frac) * 65536;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        r = r + (longint'(1) << (15 - i));
      end
    end
    return r;
  endfunction

  function automatic ll_tab_t build_ll();
    ll_tab_t tab;
    longint lg;
    longint half;
    for (int i = 0; i < LOGLOG_TABLE_DEPTH; i++) begin
      lg = log2_q16(64'(16 + i), 2);
      half = (lg < 0) ? 0 : lg / 2;
      tab[i] = LL_W'(log2_q16(64'(half), 16));
    end
    return tab;
  endfunction

  localparam ll_tab_t LL_TAB = build_ll();

endpackage

// File: rtl/mpe_if.sv
// Valid/ready channel interfaces for pixel items and color items.
// Depends on mpe_pkg.
interface mpe_pix_if import mpe_pkg::*; ();
  logic valid;
  logic ready;
  logic [POS_W-1:0] pixel_col;
  logic [POS_W-1:0] pixel_row;
  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mpe_color_if import mpe_pkg::*; ();
  logic valid;
  logic ready;
  logic [ITER_W-1:0] escape_count;
  logic in_set;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, output escape_count, output in_set, output red,
                  output green, output blue, input ready);
  modport sink (input valid, input escape_count, input in_set, input red,
                input green, input blue, output ready);
endinterface

// File: rtl/mpe_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on mpe_pkg.
module mpe_mul import mpe_pkg::*; (
  input  logic clk,
  input  logic [MUL_W-1:0] a,
  input  logic [MUL_W-1:0] b,
  output logic [2*MUL_W-1:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// File: rtl/mpe_div.sv
// Restoring divider, one quotient bit per cycle, for the smooth count over the limit.
// Depends on mpe_pkg.
module mpe_div import mpe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  mpe_div_req_t req,
  output logic done,
  output logic [S_W-1:0] quotient
);
  localparam int CNT_W = $clog2(S_W);

  logic busy;
  logic [CNT_W-1:0] cnt;
  logic [ITER_W-1:0] rem;
  logic [ITER_W-1:0] dvs;
  logic [S_W-1:0] quo;
  logic [ITER_W:0] rem_sh;
  logic qbit;
  logic [ITER_W:0] rem_next;

  assign rem_sh = {rem, quo[S_W-1]};
  assign qbit = rem_sh >= {1'b0, dvs};
  assign rem_next = qbit ? rem_sh - {1'b0, dvs} : rem_sh;
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(S_W - 1);
        rem <= '0;
        quo <= req.dividend;
        dvs <= req.divisor;
      end else if (busy) begin
        rem <= rem_next[ITER_W-1:0];
        quo <= {quo[S_W-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/mandelbrot_pixel_escape_color.sv
// Mandelbrot escape-time pixel colorer with smooth palette.
// After accept, c is computed from the pixel, then z is iterated up to the escape decision;
// an escaped item passes smoothing, divide and palette to the output load, an in-set item
// goes straight to it; the load waits while the previous result is still in the output.
// Throughput: one item at a time, next accept in the cycle after the result loads; one shared
// multiplier. Reset: synchronous, active high; settings return to defaults, no item held.
module mandelbrot_pixel_escape_color import mpe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mpe_pix_if.sink pix,
  mpe_color_if.source color
);
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CR = 5'd1;
  localparam logic [4:0] S_CI = 5'd2;
  localparam logic [4:0] S_CI2 = 5'd3;
  localparam logic [4:0] S_SQR = 5'd4;
  localparam logic [4:0] S_SQI = 5'd5;
  localparam logic [4:0] S_CRS = 5'd6;
  localparam logic [4:0] S_UPD = 5'd7;
  localparam logic [4:0] S_SMOOTH = 5'd8;
  localparam logic [4:0] S_DIV = 5'd9;
  localparam logic [4:0] S_P1 = 5'd10;
  localparam logic [4:0] S_P2 = 5'd11;
  localparam logic [4:0] S_P3 = 5'd12;
  localparam logic [4:0] S_P4 = 5'd13;
  localparam logic [4:0] S_P5 = 5'd14;
  localparam logic [4:0] S_P6 = 5'd15;
  localparam logic [4:0] S_P7 = 5'd16;
  localparam logic [4:0] S_P8 = 5'd17;
  localparam logic [4:0] S_P9 = 5'd18;
  localparam logic [4:0] S_P10 = 5'd19;
  localparam logic [4:0] S_P11 = 5'd20;
  localparam logic [4:0] S_DONE = 5'd21;

  localparam int OFF_W = 44;

  logic signed [COORD_W-1:0] center_real;
  logic signed [COORD_W-1:0] center_imag;
  logic [STEP_W-1:0] pixel_step;
  logic [ITER_W-1:0] iteration_limit;
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  logic [4:0] state;
  logic [POS_W-1:0] col;
  logic [POS_W-1:0] row;
  logic signed [COORD_W-1:0] cre;
  logic signed [COORD_W-1:0] cim;
  logic signed [Z_W-1:0] zre;
  logic signed [Z_W-1:0] zim;
  logic [ITER_W-1:0] n;
  logic [SQ_W-1:0] sq_r;
  logic [SQ_W-1:0] sq_i;
  logic [MAG_W-1:0] mag2;
  logic [15:0] t;
  logic [16:0] u;
  logic [16:0] t2;
  logic [16:0] t3;
  logic [16:0] u2;
  logic [16:0] u3;
  logic [16:0] vr;
  logic [16:0] vg;
  logic [16:0] vb;

  logic out_valid;
  logic [ITER_W-1:0] out_count;
  logic out_in_set;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  logic [MUL_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_b;
  logic [2*MUL_W-1:0] prod;
  mpe_div_req_t div_req;
  logic div_done;
  logic [S_W-1:0] div_q;

  logic signed [DIM_W:0] dcol;
  logic signed [DIM_W:0] drow;
  logic [DIM_W-1:0] dcol_mag;
  logic [DIM_W-1:0] drow_mag;
  logic [MUL_W-1:0] ar;
  logic [MUL_W-1:0] ai;
  logic [SQ_W-1:0] psq;
  logic [MAG_W-1:0] mag2_next;
  logic signed [Z_W+3:0] zre_next;
  logic signed [Z_W+3:0] cross2;
  logic signed [Z_W+3:0] zim_next;
  logic [MAG_W-1:0] esc_diff;
  logic [LL_IDX_W-1:0] ll_idx;
  logic signed [S_W:0] s_val;
  logic [S_W-1:0] s_clamp;
  logic [15:0] t_sat;
  logic [7:0] chan_val;
  logic [7:0] chan_blue;

  function automatic logic signed [COORD_W-1:0] coord(input logic signed [COORD_W-1:0] ctr,
                                                     input logic neg,
                                                     input logic [OFF_W-1:0] prod_mag);
    logic signed [OFF_W+1:0] off;
    logic signed [OFF_W+1:0] v;
    off = $signed({2'b00, prod_mag >> 1});
    v = (OFF_W+2)'(ctr) + (neg ? -off : off);
    if (v > (OFF_W+2)'(64'sd2147483647)) return 32'sh7FFFFFFF;
    if (v < -(OFF_W+2)'(64'sd2147483648)) return 32'sh80000000;
    return v[COORD_W-1:0];
  endfunction

  mpe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
  mpe_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quotient(div_q));

  assign dcol = $signed({1'b0, col, 1'b0}) - $signed({1'b0, frame_width});
  assign drow = $signed({1'b0, row, 1'b0}) - $signed({1'b0, frame_height});
  assign dcol_mag = dcol[DIM_W] ? DIM_W'(-dcol) : dcol[DIM_W-1:0];
  assign drow_mag = drow[DIM_W] ? DIM_W'(-drow) : drow[DIM_W-1:0];
  assign ar = zre[Z_W-1] ? MUL_W'(-zre) : MUL_W'(zre);
  assign ai = zim[Z_W-1] ? MUL_W'(-zim) : MUL_W'(zim);
  assign psq = prod[FRAC+SQ_W-1:FRAC];
  assign mag2_next = {1'b0, sq_r} + {1'b0, psq};
  assign zre_next = $signed({2'b00, sq_r}) - $signed({2'b00, sq_i}) + (Z_W+4)'(cre);
  assign cross2 = $signed({1'b0, psq, 1'b0});
  assign zim_next = ((zre[Z_W-1] != zim[Z_W-1]) ? -cross2 : cross2) + (Z_W+4)'(cim);
  assign esc_diff = mag2 - ESCAPE_SQ;
  assign ll_idx = (esc_diff[MAG_W-1:FRAC-2] > (MAG_W-FRAC+2)'(LOGLOG_TABLE_DEPTH - 1)) ?
                  LL_IDX_W'(LOGLOG_TABLE_DEPTH - 1) : esc_diff[FRAC-2+LL_IDX_W-1:FRAC-2];
  assign s_val = $signed({1'b0, ({1'b0, n} + 1'b1), 16'd0}) - $signed((S_W+1)'(LL_TAB[ll_idx]));
  assign s_clamp = s_val[S_W] ? '0 : s_val[S_W-1:0];
  assign t_sat = (div_q > S_W'(65535)) ? 16'hFFFF : div_q[15:0];
  assign chan_val = (prod[40:16] > 25'd255) ? 8'd255 : prod[23:16];
  assign chan_blue = (prod[41:17] > 25'd255) ? 8'd255 : prod[24:17];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_CR: begin
        mul_a = MUL_W'(dcol_mag);
        mul_b = MUL_W'(pixel_step);
      end
      S_CI: begin
        mul_a = MUL_W'(drow_mag);
        mul_b = MUL_W'(pixel_step);
      end
      S_SQR: begin
        mul_a = ar;
        mul_b = ar;
      end
      S_SQI: begin
        mul_a = ai;
        mul_b = ai;
      end
      S_CRS: begin
        mul_a = ar;
        mul_b = ai;
      end
      S_P1: begin
        mul_a = MUL_W'(t);
        mul_b = MUL_W'(t);
      end
      S_P2: begin
        mul_a = MUL_W'(u);
        mul_b = MUL_W'(u);
      end
      S_P3: begin
        mul_a = MUL_W'(t2);
        mul_b = MUL_W'(t);
      end
      S_P4: begin
        mul_a = MUL_W'(u2);
        mul_b = MUL_W'(u);
      end
      S_P5: begin
        mul_a = MUL_W'(u);
        mul_b = MUL_W'(t3);
      end
      S_P6: begin
        mul_a = MUL_W'(u2);
        mul_b = MUL_W'(t2);
      end
      S_P7: begin
        mul_a = MUL_W'(u3);
        mul_b = MUL_W'(t);
      end
      S_P8: begin
        mul_a = MUL_W'(vr);
        mul_b = K_RED;
      end
      S_P9: begin
        mul_a = MUL_W'(vg);
        mul_b = K_GREEN;
      end
      S_P10: begin
        mul_a = MUL_W'(vb);
        mul_b = K_BLUE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start = (state == S_SMOOTH) && (n < iteration_limit);
    div_req.dividend = s_clamp;
    div_req.divisor = iteration_limit;
  end

  assign pix.ready = (state == S_IDLE);
  assign color.valid = out_valid;
  assign color.escape_count = out_count;
  assign color.in_set = out_in_set;
  assign color.red = out_red;
  assign color.green = out_green;
  assign color.blue = out_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_real <= -32'sd134217728;
      center_imag <= '0;
      pixel_step <= STEP_W'(805306);
      iteration_limit <= ITER_W'(1000);
      frame_width <= DIM_W'(1000);
      frame_height <= DIM_W'(800);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_REAL: center_real <= cfg_data;
        CFG_CENTER_IMAG: center_imag <= cfg_data;
        CFG_PIXEL_STEP: pixel_step <= cfg_data[STEP_W-1:0];
        CFG_ITER_LIMIT: iteration_limit <= cfg_data[ITER_W-1:0];
        CFG_FRAME_WIDTH: frame_width <= cfg_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && color.ready && state != S_DONE) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pix.valid) begin
            col <= pix.pixel_col;
            row <= pix.pixel_row;
            state <= S_CR;
          end
        end
        S_CR: state <= S_CI;
        S_CI: begin
          cre <= coord(center_real, dcol[DIM_W], prod[OFF_W-1:0]);
          state <= S_CI2;
        end
        S_CI2: begin
          cim <= coord(center_imag, drow[DIM_W], prod[OFF_W-1:0]);
          zre <= '0;
          zim <= '0;
          n <= '0;
          state <= S_SQR;
        end
        S_SQR: state <= S_SQI;
        S_SQI: begin
          sq_r <= psq;
          state <= S_CRS;
        end
        S_CRS: begin
          sq_i <= psq;
          mag2 <= mag2_next;
          if (mag2_next > ESCAPE_SQ || n >= iteration_limit) state <= S_SMOOTH;
          else state <= S_UPD;
        end
        S_UPD: begin
          zre <= zre_next[Z_W-1:0];
          zim <= zim_next[Z_W-1:0];
          n <= n + 1'b1;
          state <= S_SQR;
        end
        S_SMOOTH: begin
          if (n >= iteration_limit) begin
            red_next <= '0;
            green_next <= '0;
            blue_next <= '0;
            state <= S_DONE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            t <= t_sat;
            u <= 17'h10000 - {1'b0, t_sat};
            state <= S_P1;
          end
        end
        S_P1: state <= S_P2;
        S_P2: begin
          t2 <= {1'b0, prod[31:16]};
          state <= S_P3;
        end
        S_P3: begin
          u2 <= prod[32:16];
          state <= S_P4;
        end
        S_P4: begin
          t3 <= {1'b0, prod[31:16]};
          state <= S_P5;
        end
        S_P5: begin
          u3 <= prod[32:16];
          state <= S_P6;
        end
        S_P6: begin
          vr <= prod[32:16];
          state <= S_P7;
        end
        S_P7: begin
          vg <= prod[32:16];
          state <= S_P8;
        end
        S_P8: begin
          vb <= prod[32:16];
          state <= S_P9;
        end
        S_P9: begin
          red_next <= chan_val;
          state <= S_P10;
        end
        S_P10: begin
          green_next <= chan_val;
          state <= S_P11;
        end
        S_P11: begin
          blue_next <= chan_blue;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || color.ready) begin
            out_valid <= 1'b1;
            out_count <= n;
            out_in_set <= (n >= iteration_limit);
            out_red <= red_next;
            out_green <= green_next;
            out_blue <= blue_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_in_set_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_in_set) |-> (out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0))
    else $error("in-set item has nonzero color");
  a_count_le_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (n < iteration_limit))
    else $error("iteration past limit");
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside its wait state");
  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !out_valid) |=> (out_valid && state == S_IDLE))
    else $error("finished item not loaded into output register");
`endif

endmodule

// File: tb/tb_mandelbrot_pixel_escape_color.sv
// Testbench for mandelbrot_pixel_escape_color: pixel items go in, escape counts and
// palette colors come out and are checked against a predictor written here.
// Depends on mpe_pkg, mpe_pix_if and mpe_color_if.
module tb_mandelbrot_pixel_escape_color;
  import mpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ITER_W-1:0] escape_count;
    logic in_set;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mpe_pix_if pix ();
  mpe_color_if color ();

  mandelbrot_pixel_escape_color dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pix(pix.sink), .color(color.source)
  );

  always #5 clk = ~clk;

  longint center_re, center_im, step;
  int limit, width, height;
  color_t colors_due[$];
  int errors = 0;
  int src_idle = 0;
  int snk_stall = 0;
  int hold_cycles = 0;

  function automatic longint log2_fixed(logic [63:0] v, int fbits);
    int msb;
    logic [63:0] m;
    longint acc;
    if (v == 64'd0) return 0;
    msb = 63;
    while (!v[msb]) msb--;
    m = (msb > 30) ? (v >> (msb - 30)) : (v << (30 - msb));
    acc = longint'(msb - fbits) * 65536;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m[31]) begin
        m = m >> 1;
        acc += longint'(1) << b;
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] magnitude(longint a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  function automatic longint fixmul(longint a, longint b);
    logic [63:0] p;
    p = (magnitude(a) * magnitude(b)) >> FRAC;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint plane_coord(longint ctr, int pos, int dim);
    longint v;
    v = ctr + ((longint'(2 * pos) - dim) * step) / 2;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [7:0] channel(logic [63:0] prod, logic [63:0] k, int sh);
    logic [63:0] v;
    v = (prod * k) >> sh;
    return v > 255 ? 8'd255 : v[7:0];
  endfunction

  function automatic color_t predict_color(int col, int row);
    color_t c;
    longint cre, cim, zre, zim, nre, ll, s;
    logic [63:0] ar, ai, mag2, idx, half, t, u, t2, t3, u2, u3;
    int n, lim;
    lim = limit > MAX_ITER_BOUND ? MAX_ITER_BOUND : limit;
    cre = plane_coord(center_re, col, width);
    cim = plane_coord(center_im, row, height);
    zre = 0;
    zim = 0;
    n = 0;
    forever begin
      ar = magnitude(zre);
      ai = magnitude(zim);
      mag2 = ((ar * ar) >> FRAC) + ((ai * ai) >> FRAC);
      if (mag2 > (64'd4 << FRAC) || n >= lim) break;
      nre = fixmul(zre, zre) - fixmul(zim, zim) + cre;
      zim = 2 * fixmul(zre, zim) + cim;
      zre = nre;
      n++;
    end
    c.escape_count = ITER_W'(n);
    c.in_set = 1'b0;
    c.red = '0;
    c.green = '0;
    c.blue = '0;
    if (n >= lim) begin
      c.in_set = 1'b1;
      return c;
    end
    idx = (mag2 - (64'd4 << FRAC)) >> (FRAC - 2);
    if (idx >= LOGLOG_TABLE_DEPTH) idx = LOGLOG_TABLE_DEPTH - 1;
    ll = log2_fixed(16 + idx, 2);
    half = (ll < 0) ? 0 : 64'(ll) / 2;
    ll = log2_fixed(half, 16);
    s = longint'(n + 1) * 65536 - ll;
    if (s < 0) s = 0;
    t = 64'(s) / lim;
    if (t > 65535) t = 65535;
    u = 65536 - t;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    u2 = (u * u) >> 16;
    u3 = (u2 * u) >> 16;
    c.red = channel((u * t3) >> 16, 2295, 16);
    c.green = channel((u2 * t2) >> 16, 3825, 16);
    c.blue = channel((u3 * t) >> 16, 4335, 17);
    return c;
  endfunction

  task automatic report(string field, longint want, longint got);
    $display("mismatch %s: expected %0d got %0d at %0t", field, want, got, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    color_t want;
    if (color.valid && color.ready) begin
      if (colors_due.size() == 0) begin
        report("unexpected item", 0, 1);
      end else begin
        want = colors_due.pop_front();
        if (color.escape_count !== want.escape_count)
          report("escape_count", want.escape_count, color.escape_count);
        if (color.in_set !== want.in_set) report("in_set", want.in_set, color.in_set);
        if (color.red !== want.red) report("red", want.red, color.red);
        if (color.green !== want.green) report("green", want.green, color.green);
        if (color.blue !== want.blue) report("blue", want.blue, color.blue);
      end
    end
    if (hold_cycles > 0) begin
      color.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      color.ready <= ($urandom_range(99) >= snk_stall);
    end
  end

  task automatic send_pixel(int col, int row);
    while ($urandom_range(99) < src_idle) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel_col <= POS_W'(col);
    pix.pixel_row <= POS_W'(row);
    colors_due.push_back(predict_color(col & 1023, row & 1023));
    do @(posedge clk); while (!pix.ready);
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_CENTER_REAL: center_re = longint'(signed'(data));
      CFG_CENTER_IMAG: center_im = longint'(signed'(data));
      CFG_PIXEL_STEP: step = longint'(data[30:0]);
      CFG_ITER_LIMIT: limit = int'(data[11:0]);
      CFG_FRAME_WIDTH: width = int'(data[10:0]);
      CFG_FRAME_HEIGHT: height = int'(data[10:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_view(logic [31:0] re, logic [31:0] im, logic [31:0] stp,
                          int lim, int w, int h);
    write_reg(CFG_CENTER_REAL, re);
    write_reg(CFG_CENTER_IMAG, im);
    write_reg(CFG_PIXEL_STEP, stp);
    write_reg(CFG_ITER_LIMIT, lim);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  task automatic test_reset_view();
    send_pixel(500, 400);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(999, 0);
    drain();
  endtask

  task automatic test_edge_cases();
    // limit zero, then limit one for saturated t
    set_view(32'hF800_0000, 0, 12582912, 0, 64, 48);
    send_pixel(32, 24);
    send_pixel(1023, 0);
    drain();
    write_reg(CFG_ITER_LIMIT, 1);
    send_pixel(0, 0);
    send_pixel(63, 47);
    send_pixel(32, 24);
    drain();
    // saturated coordinates and table index past the end
    set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 4095, 2047, 0);
    send_pixel(1023, 1023);
    send_pixel(0, 0);
    send_pixel(0, 1023);
    drain();
    write_reg(CFG_CENTER_REAL, 32'h7000_0000);
    write_reg(CFG_CENTER_IMAG, 32'h7000_0000);
    write_reg(CFG_PIXEL_STEP, 1);
    send_pixel(0, 0);
    drain();
    // maximum limit, zero frame width
    set_view(32'hF800_0000, 0, 1, 4095, 0, 1024);
    send_pixel(0, 512);
    drain();
    write_reg(CFG_CENTER_REAL, 32'hE000_0000);
    send_pixel(1, 700);
    drain();
  endtask

  task automatic test_backpressure();
    set_view(32'hF800_0000, 0, 12582912, 24, 64, 48);
    hold_cycles = 600;
    for (int i = 0; i < 20; i++) send_pixel($urandom_range(63), $urandom_range(47));
    drain();
  endtask

  task automatic run_random(int items, int idle, int stall);
    int col, row;
    src_idle = idle;
    snk_stall = stall;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 85) begin
        col = (width == 0) ? 0 : $urandom_range((width > 1024 ? 1024 : width) - 1);
        row = (height == 0) ? 0 : $urandom_range((height > 1024 ? 1024 : height) - 1);
      end else begin
        col = $urandom_range(1023);
        row = $urandom_range(1023);
      end
      send_pixel(col, row);
      if ($urandom_range(59) == 0) drain();
    end
    drain();
    src_idle = 0;
    snk_stall = 0;
  endtask

  task automatic test_random();
    set_view(32'hF800_0000, 0, 12582912, 64, 64, 48);
    run_random(150, 0, 0);
    set_view(-201326592, 26843546, 524288, 200, 40, 30);
    run_random(150, 78, 0);
    set_view(0, 0, 8388608, 16, 128, 96);
    run_random(150, 0, 78);
    set_view($urandom_range(32'h4000_0000) - 32'h2000_0000,
             $urandom_range(32'h4000_0000) - 32'h2000_0000,
             $urandom_range(8388608, 65536), 100,
             $urandom_range(1024, 1), $urandom_range(1024, 1));
    run_random(150, 30, 30);
  endtask

  initial begin
    center_re = -134217728;
    center_im = 0;
    step = 805306;
    limit = 1000;
    width = 1000;
    height = 800;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.pixel_col = '0;
    pix.pixel_row = '0;
    color.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_view();
    test_edge_cases();
    test_backpressure();
    test_random();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("[mandelbrot_pixel_escape_color] OK");
    else $display("[mandelbrot_pixel_escape_color] ERROR");
    $finish;
  end

  initial begin
    #60ms;
    $display("[mandelbrot_pixel_escape_color] ERROR");
    $finish;
  end

endmodule

// File: mandelbrot_pixel_escape_color.f
rtl/mpe_pkg.sv
rtl/mpe_if.sv
rtl/mpe_mul.sv
rtl/mpe_div.sv
rtl/mandelbrot_pixel_escape_color.sv
tb/tb_mandelbrot_pixel_escape_color.sv
